>>> hw/rtl/sbsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbsr_pkg
// Shared types and constants for the spectral bin shift remapper.
// ----------------------------------------------------------------------------
package sbsr_pkg;

    localparam int IDX_W      = 11;
    localparam int DATA_W     = 24;
    localparam int SCALE_W    = 15;
    localparam int LOW_W      = 11;
    localparam int FRAC_W     = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam int DEFAULT_WINDOW_LEN = 2048;

    localparam logic [SCALE_W-1:0] ONE_Q14   = 15'd16384;
    localparam logic [SCALE_W-1:0] RND_Q14   = 15'd8192;
    localparam logic [LOW_W-1:0]   LOW_RESET = 11'd1;

    localparam logic signed [DATA_W-1:0] MIN24 = 24'sh800000;
    localparam logic signed [DATA_W-1:0] MAX24 = 24'sh7FFFFF;

    // opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SHIFT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BIN = 1'd1;

    typedef struct packed {
        logic [1:0]               op;
        logic [IDX_W-1:0]         bin_index;
        logic signed [DATA_W-1:0] bin_real;
        logic signed [DATA_W-1:0] bin_imag;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [DATA_W-1:0] out_real;
        logic signed [DATA_W-1:0] out_imag;
    } rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/spectral_bin_shift_remapper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_bin_shift_remapper
// Spectral pitch shifter: bins 0..N/2 are held in one memory and moved in
// place to round(i*scale) by a read-modify-write sequencer.
//
//   port group | dir | handshake         | word
//   -----------+-----+-------------------+------------------------------------
//   req        | in  | req_valid/ready   | op, bin_index, bin_real, bin_imag
//   rsp        | out | rsp_valid/ready   | out_index, out_real, out_imag
//   cfg        | in  | cfg_we            | cfg_index, cfg_data
//
// Loads and reads: one word per cycle while req_ready is high; a read word
// passes the memory read register, then the output register. The shift
// pass visits each bin with a read state and a write state (the single
// write port carries both the destination write and the source clear);
// req_ready is low during the pass and any wait for a pending readout.
// Reset clears control and registers; bin storage is undefined until
// loaded and gets no clearing pass. A stalled rsp holds one pending read;
// further words wait until it moves.
// ----------------------------------------------------------------------------
module spectral_bin_shift_remapper
#(
    parameter int WINDOW_LEN = sbsr_pkg::DEFAULT_WINDOW_LEN
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_ready,
    input  wire sbsr_pkg::req_t                      req,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_ready,
    output sbsr_pkg::rsp_t                           rsp,
    input  wire logic                                cfg_we,
    input  wire logic [sbsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sbsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sbsr_pkg::*;

    localparam int HALF   = WINDOW_LEN / 2;
    localparam int ADDR_W = $clog2(HALF + 1);
    localparam int PROD_W = ADDR_W + SCALE_W + 1;
    localparam int DEST_W = PROD_W - FRAC_W;
    localparam int MEM_W  = 2 * DATA_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DRAIN = 5'b00010,
        ST_RD    = 5'b00100,
        ST_WR    = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    // configuration
    logic [SCALE_W-1:0] scale_reg;
    logic [LOW_W-1:0]   low_bin_reg;

    // sequencer
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  i_reg, i_next;
    logic [DEST_W-1:0]  dest_reg, dest_next;
    logic               up_reg, up_next;
    logic               zpend_reg, zpend_next;
    logic [ADDR_W-1:0]  zaddr_reg, zaddr_next;

    // pending readout
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg;
    logic               pend_mirror_reg;
    logic               pend_blank_reg;

    // memory
    logic [MEM_W-1:0]   mem [0:HALF];
    logic [MEM_W-1:0]   rdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  raddr;
    logic               mem_we;
    logic [ADDR_W-1:0]  waddr;
    logic [MEM_W-1:0]   wdata;

    logic               accept;
    logic               adv;
    logic               out_load;
    logic [31:0]        idx_w;
    logic [31:0]        mirror_w;
    logic [31:0]        low_w;
    logic               in_half;
    logic               in_win;
    logic [PROD_W-1:0]  prod;
    logic               last_bin;
    logic               pass_empty;

    assign adv       = !rsp_valid || rsp_ready;
    assign out_load  = pend_reg && adv;
    assign req_ready = (state_reg == ST_IDLE) && (!pend_reg || adv);
    assign accept    = req_valid && req_ready;

    assign idx_w    = 32'(req.bin_index);
    assign mirror_w = 32'(WINDOW_LEN) - idx_w;
    assign in_half  = idx_w <= 32'(HALF);
    assign in_win   = idx_w < 32'(WINDOW_LEN);
    assign low_w    = 32'(low_bin_reg);

    assign pass_empty = (low_w >= 32'(HALF)) || (scale_reg == ONE_Q14);
    assign prod       = PROD_W'(i_reg) * PROD_W'(scale_reg) + PROD_W'(RND_Q14);
    assign last_bin   = up_reg ? (i_reg == ADDR_W'(HALF - 1))
                               : (i_reg == low_w[ADDR_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= ONE_Q14;
            low_bin_reg <= LOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCALE:   scale_reg   <= cfg_data;
                CFG_LOW_BIN: low_bin_reg <= cfg_data[LOW_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        dest_next  = dest_reg;
        up_next    = up_reg;
        zpend_next = zpend_reg;
        zaddr_next = zaddr_reg;
        pend_next  = out_load ? 1'b0 : pend_reg;
        mem_re     = 1'b0;
        raddr      = i_reg;
        mem_we     = 1'b0;
        waddr      = zaddr_reg;
        wdata      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.op)
                        OP_LOAD:
                        begin
                            mem_we = in_half;
                            waddr  = idx_w[ADDR_W-1:0];
                            wdata  = {req.bin_real, req.bin_imag};
                        end
                        OP_SHIFT:
                        begin
                            state_next = ST_DRAIN;
                        end
                        OP_READ:
                        begin
                            pend_next = 1'b1;
                            mem_re    = in_win;
                            raddr     = in_half ? idx_w[ADDR_W-1:0]
                                                : mirror_w[ADDR_W-1:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                // the pass reuses the read port: let a pending readout go first
                if (!pend_reg)
                begin
                    zpend_next = 1'b0;
                    if (pass_empty)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        up_next    = scale_reg < ONE_Q14;
                        i_next     = (scale_reg < ONE_Q14) ? low_w[ADDR_W-1:0]
                                                           : ADDR_W'(HALF - 1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                mem_re     = 1'b1;
                raddr      = i_reg;
                mem_we     = zpend_reg;
                waddr      = zaddr_reg;
                zpend_next = 1'b0;
                dest_next  = prod[PROD_W-1:FRAC_W];
                state_next = ST_WR;
            end
            ST_WR:
            begin
                mem_we     = (dest_reg != DEST_W'(i_reg)) && (dest_reg <= DEST_W'(HALF));
                waddr      = dest_reg[ADDR_W-1:0];
                wdata      = rdata;
                zpend_next = dest_reg != DEST_W'(i_reg);
                zaddr_next = i_reg;
                if (last_bin)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    i_next     = up_reg ? i_reg + ADDR_W'(1) : i_reg - ADDR_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_FLUSH:
            begin
                mem_we     = zpend_reg;
                waddr      = zaddr_reg;
                zpend_next = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            zpend_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            zpend_reg <= zpend_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        dest_reg  <= dest_next;
        up_reg    <= up_next;
        zaddr_reg <= zaddr_next;
        if (accept && (req.op == OP_READ))
        begin
            pend_idx_reg    <= req.bin_index;
            pend_mirror_reg <= !in_half;
            pend_blank_reg  <= !in_win;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata <= mem[raddr];
        end
    end

    sbsr_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .index     (pend_idx_reg),
        .rd_real   (rdata[MEM_W-1:DATA_W]),
        .rd_imag   (rdata[DATA_W-1:0]),
        .mirror    (pend_mirror_reg),
        .blank     (pend_blank_reg),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(waddr) <= 32'(HALF)))
        else $error("bin store write out of range");

    a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (waddr != raddr))
        else $error("read and write hit the same bin in one cycle");

    a_pass_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RD) || (state_reg == ST_WR) || (state_reg == ST_FLUSH))
        |-> !pend_reg)
        else $error("readout pending while shift pass owns the read port");

    a_read_pends: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.op == OP_READ)) |=> pend_reg)
        else $error("accepted read word left no pending readout");

endmodule
`default_nettype wire

>>> hw/rtl/sbsr_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbsr_out_stage
// Output register for readout words: applies the conjugate mirror with
// saturation and blanks reads beyond the window.
// ----------------------------------------------------------------------------
module sbsr_out_stage
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic [sbsr_pkg::IDX_W-1:0]        index,
    input  wire logic signed [sbsr_pkg::DATA_W-1:0] rd_real,
    input  wire logic signed [sbsr_pkg::DATA_W-1:0] rd_imag,
    input  wire logic                              mirror,
    input  wire logic                              blank,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output sbsr_pkg::rsp_t                         rsp
);
    import sbsr_pkg::*;

    logic                       valid_reg;
    rsp_t                       rsp_reg;
    rsp_t                       rsp_next;
    logic signed [DATA_W-1:0]   imag_neg;

    // conjugate: negation of the most negative value saturates
    assign imag_neg = (rd_imag == MIN24) ? MAX24 : -rd_imag;

    always_comb
    begin
        rsp_next.out_index = index;
        if (blank)
        begin
            rsp_next.out_real = '0;
            rsp_next.out_imag = '0;
        end
        else
        begin
            rsp_next.out_real = rd_real;
            rsp_next.out_imag = mirror ? imag_neg : rd_imag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
